@@ hdl/lscc_pkg.sv @@
// Shared types and constants for the line sensor calibrate and centroid core.
`timescale 1ns / 1ps

package lscc_pkg;

  localparam int MaxChannels = 16;
  localparam int ChW         = 4;
  localparam int RawW        = 16;
  localparam int ValW        = 10;
  localparam int PosW        = 14;
  localparam int SumW        = 15;
  localparam int WsumW       = 28;
  localparam int NumW        = 26;
  localparam int DivNumW     = 28;
  localparam int DivDenW     = 16;
  localparam int CountW      = 5;

  localparam int FullScale   = 1000;
  localparam int HalfScale   = FullScale / 2;
  localparam int RawTop      = 65535;
  localparam int SumTop      = 32767;
  localparam int PosTop      = 15000;
  localparam int CountReset  = 8;

  localparam int QueueDepth  = 4;
  localparam int QueuePtrW   = $clog2(QueueDepth);

  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 5;

  localparam logic [CfgIdxW-1:0] CfgCalibrateMode = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgChannelCount  = CfgIdxW'(1);

  typedef struct packed {
    logic [ChW-1:0]  channel;
    logic [RawW-1:0] raw_time;
    logic            last_channel;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] calibrated_value;
    logic [PosW-1:0] position;
    logic            position_valid;
    logic            no_line;
  } out_item_t;

  // One measure item as handed from the front to the back.
  typedef struct packed {
    logic               empty;
    logic [NumW-1:0]    num;
    logic [DivDenW-1:0] den;
    logic [ChW-1:0]     channel;
    logic               last;
  } task_t;

endpackage

@@ hdl/line_sensor_calibrate_centroid_core.sv @@
// Top level of the line sensor calibrate and centroid core.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_item_i  (channel, raw_time, last_channel)
//   out      output     out_valid_o / out_ready_i out_item_o (calibrated_value, position,
//                                                             position_valid, no_line)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Calibrate item: always accepted, range table updated, no result.
// Measure item: the back end runs the scaling divider plus bookkeeping and takes the next item
// only once the result is taken on out_ready_i; an empty range skips the divider, and a
// frame-closing item adds the position division.
// A four-entry queue lets the front keep taking items while a result waits on out_ready_i.
// Reset sets minima to 65535, maxima and sums to zero, calibrate_mode 0, channel_count 8.
`timescale 1ns / 1ps

module line_sensor_calibrate_centroid_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lscc_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lscc_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lscc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lscc_pkg::CfgDataW-1:0] cfg_data_i
);
  import lscc_pkg::*;

  logic              cal_mode_q;
  logic [CountW-1:0] chan_count_q;
  logic              push, full, pop_valid, pop_ready;
  task_t             push_task, pop_task;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_mode_q   <= 1'b0;
      chan_count_q <= CountW'(CountReset);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCalibrateMode: cal_mode_q   <= cfg_data_i[0];
        CfgChannelCount:  chan_count_q <= cfg_data_i[CountW-1:0];
        default:          ;
      endcase
    end
  end

  lscc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_mode_i  (cal_mode_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_task_o (push_task),
    .full_i      (full)
  );

  lscc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_task_i (push_task),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_task_o  (pop_task)
  );

  lscc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chan_count_i (chan_count_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_task_i   (pop_task),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

@@ hdl/lscc_front.sv @@
// Front end: accepts items, keeps per-channel calibration range, prepares scaling.
`timescale 1ns / 1ps

module lscc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cal_mode_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lscc_pkg::in_item_t in_item_i,
  output logic               push_o,
  output lscc_pkg::task_t    push_task_o,
  input  logic               full_i
);
  import lscc_pkg::*;

  localparam int Depth = 2 ** ChW;

  logic [RawW-1:0] min_q [Depth];
  logic [RawW-1:0] max_q [Depth];
  logic [RawW-1:0] lo, hi, diff;
  logic            accept;

  assign in_ready_o = cal_mode_i | ~full_i;
  assign accept     = in_valid_i & in_ready_o;

  assign lo   = min_q[in_item_i.channel];
  assign hi   = max_q[in_item_i.channel];
  assign diff = in_item_i.raw_time - lo;

  always_comb begin
    push_o                   = accept & ~cal_mode_i;
    push_task_o.empty        = (hi <= lo) | (in_item_i.raw_time <= lo);
    push_task_o.num          = NumW'(diff) * NumW'(FullScale);
    push_task_o.den          = hi - lo;
    push_task_o.channel      = in_item_i.channel;
    push_task_o.last         = in_item_i.last_channel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        min_q[i] <= RawW'(RawTop);
        max_q[i] <= '0;
      end
    end else if (accept && cal_mode_i) begin
      if (in_item_i.raw_time < lo) begin
        min_q[in_item_i.channel] <= in_item_i.raw_time;
      end
      if (in_item_i.raw_time > hi) begin
        max_q[in_item_i.channel] <= in_item_i.raw_time;
      end
    end
  end

endmodule

@@ hdl/lscc_fifo.sv @@
// Short queue of measure items between front and back.
`timescale 1ns / 1ps

module lscc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lscc_pkg::task_t push_task_i,
  output logic            full_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output lscc_pkg::task_t pop_task_o
);
  import lscc_pkg::*;

  task_t                entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   count_q;
  logic                 pop;

  assign full_o      = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign pop_valid_o = (count_q != '0);
  assign pop_task_o  = entry_q[rd_q];
  assign pop         = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_task_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   count_q <= (QueuePtrW+1)'(QueueDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_i && !pop) |=> pop_valid_o)
    else $error("pushed item not visible");

endmodule

@@ hdl/lscc_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module lscc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lscc_pkg::DivNumW-1:0] num_i,
  input  logic [lscc_pkg::DivDenW-1:0] den_i,
  output logic                         done_o,
  output logic [lscc_pkg::DivNumW-1:0] quo_o
);
  import lscc_pkg::*;

  localparam int CntW = $clog2(DivNumW);

  logic                busy_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [DivDenW-1:0]  rem_q, den_q;
  logic [DivNumW-1:0]  quo_q;
  logic [DivDenW:0]    shifted, diff;
  logic                ge;

  assign shifted = {rem_q, quo_q[DivNumW-1]};
  assign ge      = (shifted >= {1'b0, den_q});
  assign diff    = shifted - {1'b0, den_q};
  assign done_o  = done_q;
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DivDenW-1:0] : shifted[DivDenW-1:0];
      quo_q <= {quo_q[DivNumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivNumW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/lscc_back.sv @@
// Back end: scaling division, frame accumulation, position and result register.
`timescale 1ns / 1ps

module lscc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lscc_pkg::CountW-1:0] chan_count_i,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  lscc_pkg::task_t             pop_task_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lscc_pkg::out_item_t         out_item_o
);
  import lscc_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScale = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StAcc   = 3'd3;
  localparam logic [2:0] StPos   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  localparam int VchW = ValW + ChW;
  localparam int WW   = VchW + 10;

  logic [2:0]          state_q, state_d;
  logic [ChW-1:0]      ch_q, ch_d;
  logic                last_q, last_d;
  logic [ValW-1:0]     v_q, v_d;
  logic [VchW-1:0]     vch_q, vch_d;
  logic [SumW-1:0]     vsum_q, vsum_d, vsum_new;
  logic [WsumW-1:0]    wsum_q, wsum_d, wsum_new;
  out_item_t           out_q, out_d;
  logic [SumW:0]       vsum_add;
  logic [WsumW:0]      wsum_add;
  logic [WW-1:0]       w;
  logic [CountW-1:0]   n_clamp;
  logic [PosW-1:0]     midpoint;
  logic                div_start, div_done;
  logic [DivNumW-1:0]  div_num, div_quo;
  logic [DivDenW-1:0]  div_den;

  lscc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign pop_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_item_o  = out_q;

  assign vsum_add = {1'b0, vsum_q} + (SumW+1)'(v_q);
  assign vsum_new = (vsum_add > (SumW+1)'(SumTop)) ? SumW'(SumTop) : vsum_add[SumW-1:0];
  assign w        = WW'(vch_q) * WW'(FullScale);
  assign wsum_add = {1'b0, wsum_q} + (WsumW+1)'(w);
  assign wsum_new = wsum_add[WsumW] ? '1 : wsum_add[WsumW-1:0];

  always_comb begin
    if (chan_count_i == '0) begin
      n_clamp = CountW'(1);
    end else if (chan_count_i > CountW'(MaxChannels)) begin
      n_clamp = CountW'(MaxChannels);
    end else begin
      n_clamp = chan_count_i;
    end
  end
  assign midpoint = PosW'(n_clamp - 1'b1) * PosW'(HalfScale);

  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    last_d    = last_q;
    v_d       = v_q;
    vch_d     = vch_q;
    vsum_d    = vsum_q;
    wsum_d    = wsum_q;
    out_d     = out_q;
    div_start = 1'b0;
    div_num   = DivNumW'(pop_task_i.num);
    div_den   = pop_task_i.den;
    unique case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          ch_d   = pop_task_i.channel;
          last_d = pop_task_i.last;
          if (pop_task_i.empty) begin
            v_d     = '0;
            state_d = StMul;
          end else begin
            div_start = 1'b1;
            state_d   = StScale;
          end
        end
      end
      StScale: begin
        if (div_done) begin
          v_d = (div_quo > DivNumW'(FullScale)) ? ValW'(FullScale) : div_quo[ValW-1:0];
          state_d = StMul;
        end
      end
      StMul: begin
        vch_d   = VchW'(v_q) * VchW'(ch_q);
        state_d = StAcc;
      end
      StAcc: begin
        out_d.calibrated_value = v_q;
        out_d.position         = '0;
        out_d.position_valid   = last_q;
        out_d.no_line          = 1'b0;
        vsum_d                 = vsum_new;
        wsum_d                 = wsum_new;
        state_d                = StOut;
        if (last_q) begin
          if (vsum_new == '0) begin
            out_d.position = midpoint;
            out_d.no_line  = 1'b1;
            vsum_d         = '0;
            wsum_d         = '0;
          end else begin
            div_start = 1'b1;
            div_num   = wsum_new;
            div_den   = DivDenW'(vsum_new);
            state_d   = StPos;
          end
        end
      end
      StPos: begin
        if (div_done) begin
          out_d.position = (div_quo > DivNumW'(PosTop)) ? PosW'(PosTop) : div_quo[PosW-1:0];
          vsum_d  = '0;
          wsum_d  = '0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    last_q <= last_d;
    v_q    <= v_d;
    vch_q  <= vch_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vsum_q  <= '0;
      wsum_q  <= '0;
    end else begin
      state_q <= state_d;
      vsum_q  <= vsum_d;
      wsum_q  <= wsum_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   div_done |-> (state_q == StScale || state_q == StPos))
    else $error("divider result with no waiting state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && out_item_o.no_line) |-> out_item_o.position_valid)
    else $error("no_line outside frame close");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> (out_item_o.calibrated_value <= ValW'(FullScale)))
    else $error("calibrated value above full scale");

endmodule

@@ dv/line_sensor_calibrate_centroid_core_tb.sv @@
// Self-checking testbench for the line sensor calibrate and centroid core.
`timescale 1ns / 1ps

module line_sensor_calibrate_centroid_core_tb;
  import lscc_pkg::*;

  localparam int SettleCycles = 100;
  localparam int EndCycles    = 200;
  localparam int TargetItems  = 1750;
  localparam int WsumTop      = (1 << WsumW) - 1;

  logic clk;
  logic rst_n = 1'b0;

  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  line_sensor_calibrate_centroid_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state
  logic [RawW-1:0]   range_lo [MaxChannels];
  logic [RawW-1:0]   range_hi [MaxChannels];
  int unsigned       frame_sum;
  int unsigned       frame_wsum;
  logic              cal_mode   = 1'b0;
  logic [CountW-1:0] lane_count = CountW'(CountReset);

  in_item_t  raw_readings [$];
  out_item_t pending_results [$];
  out_item_t want_item;

  logic in_fire  = 1'b0;
  logic cfg_fire = 1'b0;
  int   in_gap   = 0;
  int   out_hold = 0;
  bit   no_idle  = 1'b0;

  int mismatches = 0;
  int n_readings = 0;
  int n_cal      = 0;
  int n_results  = 0;
  int n_frames   = 0;
  int n_noline   = 0;

  int unsigned chan_base [MaxChannels];
  int unsigned chan_span [MaxChannels];

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned scale_raw(int unsigned ch, int unsigned raw);
    int unsigned lo;
    int unsigned hi;
    int unsigned q;
    lo = range_lo[ch];
    hi = range_hi[ch];
    if (hi <= lo || raw <= lo) return 0;
    q = ((raw - lo) * FullScale) / (hi - lo);
    return (q > FullScale) ? FullScale : q;
  endfunction

  function automatic void predict_reading(in_item_t it);
    int unsigned ch;
    int unsigned raw;
    int unsigned v;
    int unsigned w;
    int unsigned n;
    int unsigned pos;
    logic        nl;
    out_item_t   res;
    ch  = it.channel;
    raw = it.raw_time;
    pos = 0;
    nl  = 1'b0;
    if (cal_mode) begin
      n_cal++;
      if (raw < range_lo[ch]) range_lo[ch] = RawW'(raw);
      if (raw > range_hi[ch]) range_hi[ch] = RawW'(raw);
      return;
    end
    v = scale_raw(ch, raw);
    frame_sum += v;
    if (frame_sum > SumTop) frame_sum = SumTop;
    w = v * ch * FullScale;
    frame_wsum = (w > WsumTop - frame_wsum) ? WsumTop : frame_wsum + w;
    if (it.last_channel) begin
      if (frame_sum == 0) begin
        n = lane_count;
        if (n < 1) n = 1;
        if (n > MaxChannels) n = MaxChannels;
        pos = ((n - 1) * FullScale) / 2;
        nl  = 1'b1;
        n_noline++;
      end else begin
        pos = frame_wsum / frame_sum;
        if (pos > PosTop) pos = PosTop;
      end
      frame_sum  = 0;
      frame_wsum = 0;
      n_frames++;
    end
    res.calibrated_value = ValW'(v);
    res.position         = PosW'(pos);
    res.position_valid   = it.last_channel;
    res.no_line          = nl;
    pending_results.push_back(res);
  endfunction

  task automatic report(input string what, input int got, input int want_v);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want_v);
    end
  endtask

  // Input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (raw_readings.size() != 0) begin
        in_item  <= raw_readings.pop_front();
        in_valid <= 1'b1;
        in_gap   <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_hold != 0) begin
        out_ready <= 1'b0;
        out_hold  <= out_hold - 1;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) out_hold <= gap_len();
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    in_fire  <= rst_n && in_valid && in_ready;
    cfg_fire <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgCalibrateMode: cal_mode   = cfg_data[0];
          CfgChannelCount:  lane_count = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_reading(in_item);
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          report("result with nothing pending", out_item.calibrated_value, -1);
        end else begin
          want_item = pending_results.pop_front();
          if (out_item.calibrated_value !== want_item.calibrated_value)
            report("calibrated_value", out_item.calibrated_value,
                   want_item.calibrated_value);
          if (out_item.position !== want_item.position)
            report("position", out_item.position, want_item.position);
          if (out_item.position_valid !== want_item.position_valid)
            report("position_valid", out_item.position_valid, want_item.position_valid);
          if (out_item.no_line !== want_item.no_line)
            report("no_line", out_item.no_line, want_item.no_line);
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle(input int settle);
    do @(posedge clk);
    while (raw_readings.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic push_reading(input int ch, input int raw, input bit last);
    in_item_t it;
    it.channel      = ChW'(ch);
    it.raw_time     = RawW'(raw);
    it.last_channel = last;
    raw_readings.push_back(it);
    n_readings++;
  endtask

  function automatic int near_base(int ch);
    int raw;
    raw = int'(chan_base[ch]) + $urandom_range(0, chan_span[ch] + 1000) - 500;
    if (raw < 0) raw = 0;
    if (raw > RawTop) raw = RawTop;
    return raw;
  endfunction

  task automatic fill_calibrate();
    int n;
    int ch;
    int raw;
    n = $urandom_range(10, 40);
    for (int i = 0; i < n; i++) begin
      ch  = ($urandom_range(0, 9) < 7) ? (i % MaxChannels) : $urandom_range(0, 15);
      raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, RawTop)
                                        : chan_base[ch] + $urandom_range(0, chan_span[ch]);
      push_reading(ch, raw, (ch == MaxChannels - 1) || ($urandom_range(0, 9) == 0));
    end
  endtask

  task automatic fill_measure();
    int frames;
    int kind;
    int n;
    int start;
    int ch;
    int raw;
    frames = $urandom_range(3, 10);
    for (int f = 0; f < frames; f++) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        n     = $urandom_range(1, MaxChannels);
        start = $urandom_range(0, MaxChannels - n);
        for (int i = 0; i < n; i++) begin
          ch  = start + i;
          raw = ($urandom_range(0, 9) < 6) ? near_base(ch) : $urandom_range(0, RawTop);
          push_reading(ch, raw, i == n - 1);
        end
      end else if (kind < 93) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          push_reading($urandom_range(0, 15), $urandom_range(0, RawTop),
                       (i == n - 1) || ($urandom_range(0, 3) == 0));
        end
      end else begin
        // long frame, drives the sums into saturation
        n = $urandom_range(20, 45);
        for (int i = 0; i < n; i++) begin
          push_reading($urandom_range(0, 15), $urandom_range(60000, RawTop), i == n - 1);
        end
      end
    end
  endtask

  function automatic logic [CountW-1:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return CountW'(0);
      1:       return CountW'(1);
      2:       return CountW'(MaxChannels);
      3:       return CountW'($urandom_range(MaxChannels + 1, 31));
      default: return CountW'($urandom_range(1, MaxChannels));
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    for (int i = 0; i < MaxChannels; i++) begin
      range_lo[i]  = RawW'(RawTop);
      range_hi[i]  = '0;
      chan_base[i] = $urandom_range(0, 60000);
      chan_span[i] = $urandom_range(0, 5000);
    end
    frame_sum  = 0;
    frame_wsum = 0;
    phase      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset ranges are empty: every value is zero, frames give the midpoint.
    push_reading(0, 0, 1'b0);
    push_reading(15, RawTop, 1'b1);
    push_reading(3, 1234, 1'b1);
    wait_idle(SettleCycles);

    write_reg(CfgCalibrateMode, 5'b00001);
    write_reg(CfgIdxW'(2), 5'b11111);
    write_reg(CfgIdxW'(3), 5'b10101);
    push_reading(0, 1000, 1'b0);
    push_reading(0, 3000, 1'b0);
    push_reading(1, 0, 1'b0);
    push_reading(1, RawTop, 1'b0);
    push_reading(2, 500, 1'b0);
    push_reading(5, 2000, 1'b0);
    push_reading(5, 2001, 1'b1);
    push_reading(15, 100, 1'b0);
    push_reading(15, 60000, 1'b1);
    wait_idle(SettleCycles);

    // Below min, at max, above max, single-point range, repeated channel.
    write_reg(CfgCalibrateMode, 5'b11110);
    write_reg(CfgChannelCount, CountW'(MaxChannels));
    push_reading(0, 500, 1'b0);
    push_reading(0, 3000, 1'b0);
    push_reading(0, RawTop, 1'b0);
    push_reading(1, 32768, 1'b0);
    push_reading(2, 500, 1'b0);
    push_reading(5, 2001, 1'b0);
    push_reading(15, 0, 1'b0);
    push_reading(15, RawTop, 1'b1);
    push_reading(4, 7, 1'b1);
    wait_idle(SettleCycles);

    // Midpoint with channel count out of range, then at one.
    write_reg(CfgChannelCount, CountW'(0));
    push_reading(9, 100, 1'b1);
    wait_idle(SettleCycles);
    write_reg(CfgChannelCount, CountW'(31));
    push_reading(9, 100, 1'b1);
    wait_idle(SettleCycles);
    write_reg(CfgChannelCount, CountW'(1));
    push_reading(7, 9, 1'b1);
    wait_idle(SettleCycles);

    while (n_readings < TargetItems) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase % 3 == 0) begin
        write_reg(CfgCalibrateMode, {(CfgDataW-1)'($urandom_range(0, 15)), 1'b1});
        if ($urandom_range(0, 3) == 0) write_reg(CfgChannelCount, pick_count());
        fill_calibrate();
      end else begin
        write_reg(CfgCalibrateMode, {(CfgDataW-1)'($urandom_range(0, 15)), 1'b0});
        write_reg(CfgChannelCount, pick_count());
        if ($urandom_range(0, 7) == 0) begin
          write_reg(CfgIdxW'($urandom_range(2, 3)), CfgDataW'($urandom_range(0, 31)));
        end
        fill_measure();
      end
      wait_idle(SettleCycles);
      phase++;
    end

    wait_idle(EndCycles);
    $display("%0d readings sent (%0d calibrate) over %0d phases", n_readings, n_cal, phase);
    $display("%0d results checked, %0d frames closed, %0d with no line, %0d mismatches",
             n_results, n_frames, n_noline, mismatches);
    if (mismatches == 0) begin
      $display("line_sensor_calibrate_centroid_core_tb: done, clean");
    end else begin
      $display("line_sensor_calibrate_centroid_core_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("timeout with %0d results pending", pending_results.size());
    $display("line_sensor_calibrate_centroid_core_tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
hdl/lscc_pkg.sv
hdl/lscc_front.sv
hdl/lscc_fifo.sv
hdl/lscc_div.sv
hdl/lscc_back.sv
hdl/line_sensor_calibrate_centroid_core.sv
dv/line_sensor_calibrate_centroid_core_tb.sv
